// ----- hw/rtl/tcw_pkg.sv -----
// Shared constants and codes for the text console writer.
package tcw_pkg;

   // Default screen geometry
   localparam int COLUMNS_DEF = 80;
   localparam int ROWS_DEF    = 25;

   // Field widths of the request and response words
   localparam int CHAR_W      = 8;
   localparam int ATTR_W      = 8;
   localparam int CELL_W      = CHAR_W + ATTR_W;
   localparam int IDX_FIELD_W = 11;

   // Request type codes
   localparam logic REQ_PUT  = 1'b0;
   localparam logic REQ_READ = 1'b1;

   // Character codes
   localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
   localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;

   // Attribute and cell value after reset
   localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;
   localparam logic [CELL_W-1:0] RESET_CELL = {RESET_ATTR, SPACE_CODE};

   // Register port
   localparam int   CSR_ADDR_W       = 3;
   localparam int   CSR_DATA_W       = 32;
   localparam int   CSR_INDEX_LSB    = 2;
   localparam logic CSR_ATTR_INDEX   = 1'b0;

endpackage : tcw_pkg

// ----- hw/rtl/text_console_writer_top.sv -----
// Text console writer: character put and cell read over a ring-addressed screen memory.
//
// Text-mode console engine over a ROWS x COLUMNS screen of 16-bit cells (character in the
// low byte, attribute in the high byte). A put word stores its character with the current
// text_attribute at the cursor and advances the cursor, wrapping to the next row; a newline
// (code 10) moves the cursor to column 0 of the next row instead. Moving past the last row
// scrolls the screen up one row and fills the new bottom row with spaces in the current
// attribute. A read word returns one cell (0 when the index lies beyond the screen). Every
// request word yields one response word that carries the new cursor position. The screen
// lives in one single-port synchronous memory addressed as a ring of rows: a top-row base
// offset maps logical cell indexes to memory addresses, so a scroll only advances the base
// and rewrites one row. Sequencing: a read or a put without a scroll accesses the memory at
// the accepting edge and moves to ST_DONE; the response register loads from ST_DONE once the
// output is free, and req_ready returns with that load, so the block takes no new request
// word before the response to the last one is loaded; a response word still waiting in the
// output register holds the block in its load state. A scroll adds COLUMNS (80 by default)
// bottom-row writes through the memory port before ST_DONE. After reset the block sweeps the
// whole memory to space on light grey, one cell a cycle, with req_ready low; register writes
// are taken during that sweep. Register text_attribute sits at byte address 0.
module text_console_writer_top #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
   parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_type,
   input  logic [tcw_pkg::CHAR_W-1:0]           req_char_code,
   input  logic [tcw_pkg::IDX_FIELD_W-1:0]      req_read_index,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [tcw_pkg::IDX_FIELD_W-1:0]      rsp_cursor_pos,
   output logic                                 rsp_cell_written,
   output logic [tcw_pkg::IDX_FIELD_W-1:0]      rsp_write_index,
   output logic [tcw_pkg::CELL_W-1:0]           rsp_write_value,
   output logic                                 rsp_scrolled,
   output logic [tcw_pkg::CELL_W-1:0]           rsp_read_value,
   // register port
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [tcw_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [tcw_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [tcw_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                 csr_pready
);
   import tcw_pkg::*;

   localparam int CELLS = ROWS * COLUMNS;
   localparam int AW    = $clog2(CELLS);
   localparam int AW1   = AW + 1;
   localparam int COL_W = $clog2(COLUMNS);
   localparam int COL1  = COL_W + 1;
   localparam int ROW_W = $clog2(ROWS);
   localparam int SUM_W = ((AW > IDX_FIELD_W) ? AW : IDX_FIELD_W) + 1;

   typedef enum logic [1:0] {
      ST_CLEAR,   // sweep the whole memory after reset
      ST_IDLE,    // take a request word
      ST_SWEEP,   // blank the new bottom row after a scroll
      ST_DONE     // load the response register
   } state_type;

   // control state
   state_type              state_ff, state_in;
   logic [AW-1:0]          top_base_ff, top_base_in;   // memory address of logical row 0
   logic [AW-1:0]          pos_ff, pos_in;             // logical cursor index
   logic [COL_W-1:0]       col_ff, col_in;
   logic [ROW_W-1:0]       row_ff, row_in;
   logic [AW-1:0]          sweep_addr_ff, sweep_addr_in;
   logic [ATTR_W-1:0]      attr_ff, attr_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // payload state
   logic [AW-1:0]          sweep_last_ff, sweep_last_in;
   logic [CELL_W-1:0]      sweep_val_ff, sweep_val_in;
   logic                   pend_written_ff, pend_written_in;
   logic [AW-1:0]          pend_widx_ff, pend_widx_in;
   logic [CELL_W-1:0]      pend_wval_ff, pend_wval_in;
   logic                   pend_scrolled_ff, pend_scrolled_in;
   logic                   pend_in_range_ff, pend_in_range_in;
   logic [IDX_FIELD_W-1:0] rsp_cursor_pos_ff, rsp_cursor_pos_in;
   logic                   rsp_cell_written_ff, rsp_cell_written_in;
   logic [IDX_FIELD_W-1:0] rsp_write_index_ff, rsp_write_index_in;
   logic [CELL_W-1:0]      rsp_write_value_ff, rsp_write_value_in;
   logic                   rsp_scrolled_ff, rsp_scrolled_in;
   logic [CELL_W-1:0]      rsp_read_value_ff, rsp_read_value_in;

   // screen memory
   logic [CELL_W-1:0]      cells_mem [CELLS];
   logic [CELL_W-1:0]      mem_rdata_ff;
   logic                   mem_we;
   logic                   mem_re;
   logic [AW-1:0]          mem_addr;
   logic [CELL_W-1:0]      mem_wdata;

   // address and cursor arithmetic
   logic [SUM_W-1:0]       rd_sum;
   logic [AW-1:0]          rd_phys;
   logic                   rd_in_range;
   logic [SUM_W-1:0]       cur_sum;
   logic [AW-1:0]          cur_phys;
   logic [AW1-1:0]         top_next_sum;
   logic [AW-1:0]          top_next;
   logic [AW-1:0]          next_row_pos;
   logic [COL1-1:0]        col_inc;
   logic                   last_row;
   logic                   out_free;
   logic                   csr_wr;

   // Map logical indexes onto the row ring: one add, one compare-subtract.
   assign rd_sum      = SUM_W'(req_read_index) + SUM_W'(top_base_ff);
   assign rd_phys     = (rd_sum >= SUM_W'(CELLS)) ? AW'(rd_sum - SUM_W'(CELLS)) : AW'(rd_sum);
   assign rd_in_range = SUM_W'(req_read_index) < SUM_W'(CELLS);
   assign cur_sum     = SUM_W'(pos_ff) + SUM_W'(top_base_ff);
   assign cur_phys    = (cur_sum >= SUM_W'(CELLS)) ? AW'(cur_sum - SUM_W'(CELLS))
                                                   : AW'(cur_sum);

   // Advance the top row by one; the base wraps to 0 after the last physical row.
   assign top_next_sum = AW1'(top_base_ff) + AW1'(COLUMNS);
   assign top_next     = (top_next_sum == AW1'(CELLS)) ? '0 : AW'(top_next_sum);

   assign next_row_pos = pos_ff - AW'(col_ff) + AW'(COLUMNS);
   assign col_inc      = COL1'(col_ff) + COL1'(1);
   assign last_row     = (row_ff == ROW_W'(ROWS - 1));
   assign out_free     = !rsp_valid_ff || rsp_ready;

   // APB register port, never stalls
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[CSR_INDEX_LSB] == CSR_ATTR_INDEX)
                       ? CSR_DATA_W'(attr_ff) : '0;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in            = state_ff;
      top_base_in         = top_base_ff;
      pos_in              = pos_ff;
      col_in              = col_ff;
      row_in              = row_ff;
      sweep_addr_in       = sweep_addr_ff;
      sweep_last_in       = sweep_last_ff;
      sweep_val_in        = sweep_val_ff;
      attr_in             = attr_ff;
      pend_written_in     = pend_written_ff;
      pend_widx_in        = pend_widx_ff;
      pend_wval_in        = pend_wval_ff;
      pend_scrolled_in    = pend_scrolled_ff;
      pend_in_range_in    = pend_in_range_ff;
      rsp_cursor_pos_in   = rsp_cursor_pos_ff;
      rsp_cell_written_in = rsp_cell_written_ff;
      rsp_write_index_in  = rsp_write_index_ff;
      rsp_write_value_in  = rsp_write_value_ff;
      rsp_scrolled_in     = rsp_scrolled_ff;
      rsp_read_value_in   = rsp_read_value_ff;
      mem_we              = 1'b0;
      mem_re              = 1'b0;
      mem_addr            = '0;
      mem_wdata           = '0;

      if (csr_wr && csr_paddr[CSR_INDEX_LSB] == CSR_ATTR_INDEX) begin
         attr_in = csr_pwdata[ATTR_W-1:0];
      end

      // drop the response word once taken
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_addr  = sweep_addr_ff;
            mem_wdata = RESET_CELL;
            if (sweep_addr_ff == AW'(CELLS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               sweep_addr_in = sweep_addr_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               pend_written_in  = 1'b0;
               pend_widx_in     = '0;
               pend_wval_in     = '0;
               pend_scrolled_in = 1'b0;
               pend_in_range_in = 1'b0;
               state_in         = ST_DONE;
               if (req_type == REQ_READ) begin
                  // issue the read; data lands in mem_rdata_ff next cycle
                  pend_in_range_in = rd_in_range;
                  mem_re           = rd_in_range;
                  mem_addr         = rd_phys;
               end else begin
                  if (req_char_code != NEWLINE_CODE) begin
                     mem_we          = 1'b1;
                     mem_addr        = cur_phys;
                     mem_wdata       = {attr_ff, req_char_code};
                     pend_written_in = 1'b1;
                     pend_widx_in    = pos_ff;
                     pend_wval_in    = {attr_ff, req_char_code};
                  end
                  if (req_char_code != NEWLINE_CODE && col_inc != COL1'(COLUMNS)) begin
                     col_in = COL_W'(col_inc);
                     pos_in = pos_ff + AW'(1);
                  end else begin
                     col_in = '0;
                     if (last_row) begin
                        // scroll: old top row becomes the new bottom row, blank it
                        pend_scrolled_in = 1'b1;
                        pos_in           = AW'((ROWS - 1) * COLUMNS);
                        top_base_in      = top_next;
                        sweep_addr_in    = top_base_ff;
                        sweep_last_in    = top_base_ff + AW'(COLUMNS - 1);
                        sweep_val_in     = {attr_ff, SPACE_CODE};
                        state_in         = ST_SWEEP;
                     end else begin
                        row_in = row_ff + ROW_W'(1);
                        pos_in = next_row_pos;
                     end
                  end
               end
            end
         end
         ST_SWEEP: begin
            mem_we    = 1'b1;
            mem_addr  = sweep_addr_ff;
            mem_wdata = sweep_val_ff;
            if (sweep_addr_ff == sweep_last_ff) begin
               state_in = ST_DONE;
            end else begin
               sweep_addr_in = sweep_addr_ff + AW'(1);
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_cursor_pos_in   = IDX_FIELD_W'(pos_ff);
               rsp_cell_written_in = pend_written_ff;
               rsp_write_index_in  = IDX_FIELD_W'(pend_widx_ff);
               rsp_write_value_in  = pend_wval_ff;
               rsp_scrolled_in     = pend_scrolled_ff;
               rsp_read_value_in   = pend_in_range_ff ? mem_rdata_ff : '0;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         top_base_ff   <= '0;
         pos_ff        <= '0;
         col_ff        <= '0;
         row_ff        <= '0;
         sweep_addr_ff <= '0;
         attr_ff       <= RESET_ATTR;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         top_base_ff   <= top_base_in;
         pos_ff        <= pos_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         sweep_addr_ff <= sweep_addr_in;
         attr_ff       <= attr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      sweep_last_ff       <= sweep_last_in;
      sweep_val_ff        <= sweep_val_in;
      pend_written_ff     <= pend_written_in;
      pend_widx_ff        <= pend_widx_in;
      pend_wval_ff        <= pend_wval_in;
      pend_scrolled_ff    <= pend_scrolled_in;
      pend_in_range_ff    <= pend_in_range_in;
      rsp_cursor_pos_ff   <= rsp_cursor_pos_in;
      rsp_cell_written_ff <= rsp_cell_written_in;
      rsp_write_index_ff  <= rsp_write_index_in;
      rsp_write_value_ff  <= rsp_write_value_in;
      rsp_scrolled_ff     <= rsp_scrolled_in;
      rsp_read_value_ff   <= rsp_read_value_in;
   end

   // Single-port screen memory, registered read data
   always_ff @(posedge clock) begin
      if (mem_we) begin
         cells_mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= cells_mem[mem_addr];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cursor_pos   = rsp_cursor_pos_ff;
   assign rsp_cell_written = rsp_cell_written_ff;
   assign rsp_write_index  = rsp_write_index_ff;
   assign rsp_write_value  = rsp_write_value_ff;
   assign rsp_scrolled     = rsp_scrolled_ff;
   assign rsp_read_value   = rsp_read_value_ff;

endmodule : text_console_writer_top
